/* hw/rtl/ils_pkg.sv */
`default_nettype none

package ils_pkg;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned FUNC_W     = 3;

  localparam int unsigned S_TDATA_W = ((ADDR_W + DATA_WIDTH + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((DATA_WIDTH + ADDR_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_INSERT = 3'd2,
    FN_REMOVE = 3'd3,
    FN_GET    = 3'd4,
    FN_FIND   = 3'd5,
    FN_CLEAR  = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [ADDR_W-1:0]     pos;
    logic [DATA_WIDTH-1:0] value;
  } req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic [ADDR_W-1:0]     found_index;
    logic [CNT_W-1:0]      count;
    status_e               status;
  } res_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } ram_req_t;

endpackage

`default_nettype wire

/* hw/rtl/ils_ram.sv */
`default_nettype none

module ils_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/ils_ctrl.sv */
`default_nettype none

module ils_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  ils_pkg::req_t                   req_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output ils_pkg::res_t                   res_o,
  output ils_pkg::ram_req_t               ram_o,
  input  logic [ils_pkg::DATA_WIDTH-1:0]  ram_rdata_i
);
  import ils_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_REMOVE,
    S_INSERT,
    S_INSLAST,
    S_FIND,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  req_t                  req_q, req_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic [ADDR_W-1:0]     paddr_q, paddr_d;
  logic [DATA_WIDTH-1:0] rval_q, rval_d;
  logic [ADDR_W-1:0]     ridx_q, ridx_d;
  status_e               rstat_q, rstat_d;

  logic [CNT_W-1:0] pos_ext;
  logic [CNT_W-1:0] cnt_dec;
  logic             is_full;
  logic             is_empty;

  assign pos_ext  = {1'b0, req_q.pos};
  assign cnt_dec  = count_q - 1'b1;
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    paddr_d = paddr_q;
    rval_d  = rval_q;
    ridx_d  = ridx_q;
    rstat_d = rstat_q;
    ram_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          rval_d  = '0;
          ridx_d  = '0;
          rstat_d = STAT_OK;
          state_d = S_START;
        end
      end
      S_START: begin
        unique case (req_q.func)
          FN_PUSH: begin
            if (is_full) begin
              rstat_d = STAT_FULL;
            end else begin
              ram_o.we    = 1'b1;
              ram_o.waddr = count_q[ADDR_W-1:0];
              ram_o.wdata = req_q.value;
              count_d     = count_q + 1'b1;
            end
            state_d = S_DONE;
          end
          FN_POP: begin
            if (is_empty) begin
              rstat_d = STAT_RANGE;
              state_d = S_DONE;
            end else begin
              ram_o.re    = 1'b1;
              ram_o.raddr = cnt_dec[ADDR_W-1:0];
              count_d     = cnt_dec;
              state_d     = S_READ;
            end
          end
          FN_GET: begin
            if (pos_ext >= count_q) begin
              rstat_d = STAT_RANGE;
              state_d = S_DONE;
            end else begin
              ram_o.re    = 1'b1;
              ram_o.raddr = req_q.pos;
              state_d     = S_READ;
            end
          end
          FN_REMOVE: begin
            if (pos_ext >= count_q) begin
              rstat_d = STAT_RANGE;
              state_d = S_DONE;
            end else begin
              ram_o.re    = 1'b1;
              ram_o.raddr = req_q.pos;
              paddr_d     = req_q.pos;
              ptr_d       = pos_ext + 1'b1;
              state_d     = S_REMOVE;
            end
          end
          FN_INSERT: begin
            if (pos_ext > count_q) begin
              rstat_d = STAT_RANGE;
              state_d = S_DONE;
            end else if (is_full) begin
              rstat_d = STAT_FULL;
              state_d = S_DONE;
            end else if (pos_ext == count_q) begin
              ram_o.we    = 1'b1;
              ram_o.waddr = req_q.pos;
              ram_o.wdata = req_q.value;
              count_d     = count_q + 1'b1;
              state_d     = S_DONE;
            end else begin
              ram_o.re    = 1'b1;
              ram_o.raddr = cnt_dec[ADDR_W-1:0];
              paddr_d     = cnt_dec[ADDR_W-1:0];
              state_d     = S_INSERT;
            end
          end
          FN_FIND: begin
            if (is_empty) begin
              rstat_d = STAT_MISSING;
              state_d = S_DONE;
            end else begin
              ram_o.re    = 1'b1;
              ram_o.raddr = '0;
              paddr_d     = '0;
              ptr_d       = CNT_W'(1);
              state_d     = S_FIND;
            end
          end
          FN_CLEAR: begin
            count_d = '0;
            state_d = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_READ: begin
        rval_d  = ram_rdata_i;
        state_d = S_DONE;
      end
      S_REMOVE: begin
        if (paddr_q == req_q.pos) begin
          rval_d = ram_rdata_i;
        end else begin
          ram_o.we    = 1'b1;
          ram_o.waddr = paddr_q - 1'b1;
          ram_o.wdata = ram_rdata_i;
        end
        if (ptr_q < count_q) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = ptr_q[ADDR_W-1:0];
          paddr_d     = ptr_q[ADDR_W-1:0];
          ptr_d       = ptr_q + 1'b1;
        end else begin
          count_d = cnt_dec;
          state_d = S_DONE;
        end
      end
      S_INSERT: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = paddr_q + 1'b1;
        ram_o.wdata = ram_rdata_i;
        if (paddr_q != req_q.pos) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = paddr_q - 1'b1;
          paddr_d     = paddr_q - 1'b1;
        end else begin
          state_d = S_INSLAST;
        end
      end
      S_INSLAST: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = req_q.pos;
        ram_o.wdata = req_q.value;
        count_d     = count_q + 1'b1;
        state_d     = S_DONE;
      end
      S_FIND: begin
        if (ram_rdata_i == req_q.value) begin
          ridx_d  = paddr_q;
          rstat_d = STAT_OK;
          state_d = S_DONE;
        end else if (ptr_q < count_q) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = ptr_q[ADDR_W-1:0];
          paddr_d     = ptr_q[ADDR_W-1:0];
          ptr_d       = ptr_q + 1'b1;
        end else begin
          rstat_d = STAT_MISSING;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    ptr_q   <= ptr_d;
    paddr_q <= paddr_d;
    rval_q  <= rval_d;
    ridx_q  <= ridx_d;
    rstat_q <= rstat_d;
  end

  assign req_ready_o       = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.value       = rval_q;
  assign res_o.found_index = ridx_q;
  assign res_o.count       = count_q;
  assign res_o.status      = rstat_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the depth.");

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_o.we && ram_o.re) |-> (ram_o.waddr != ram_o.raddr))
    else $error("Read and write hit the same entry in one cycle.");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(count_q))
    else $error("Entry count changed without a transaction in progress.");

  a_scan_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REMOVE || state_q == S_FIND) |-> (ptr_q <= count_q))
    else $error("Scan pointer ran past the entry count.");

endmodule

`default_nettype wire

/* hw/rtl/indexed_list_store.sv */
// Channel  Direction  tdata (low bit up)                         tuser
// s_axis   in         position[7:0], value_in[39:8]              func[2:0]
// m_axis   out        value_out[31:0], found_index[39:32],       status[1:0]
//                     count[48:40], zero[55:49]
//
// One transaction at a time. Push, clear and an unused func finish without a read;
// pop and get wait for one read. Insert, remove and find step through the entries
// moved or compared one at a time, set by the single read port of the entry memory.
// A finished result waits in an output register while the next transaction is accepted.
// Reset clears the count and the control state; the entry memory is not cleared.
`default_nettype none

module indexed_list_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ils_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // position, value_in
  input  logic [ils_pkg::FUNC_W-1:0]     s_axis_tuser,  // func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ils_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // value_out, found_index, count
  output logic [1:0]                     m_axis_tuser   // status
);
  import ils_pkg::*;

  req_t                  req;
  res_t                  res;
  ram_req_t              ram_req;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  res_valid;
  logic                  res_ready;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_res_q;

  assign req.func  = s_axis_tuser;
  assign req.pos   = s_axis_tdata[ADDR_W-1:0];
  assign req.value = s_axis_tdata[ADDR_W +: DATA_WIDTH];

  ils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  ils_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({out_res_q.count, out_res_q.found_index, out_res_q.value});
  assign m_axis_tuser  = out_res_q.status;

endmodule

`default_nettype wire

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned RANDOM_REQUESTS = 1900;

  typedef enum int {PH_FILL, PH_GROW, PH_SHRINK, PH_MIX} phase_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_e;

  class list_tracker;
    logic [DATA_WIDTH-1:0] slots[DEPTH];
    int unsigned n_used;
    res_t expected_q[$];
    int unsigned mismatches;

    function new();
      n_used = 0;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function void take_request(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] pos,
                               logic [DATA_WIDTH-1:0] val);
      res_t r;
      int unsigned i;
      r = '0;
      r.status = STAT_OK;
      case (fn)
        FN_PUSH: begin
          if (n_used >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            slots[n_used] = val;
            n_used++;
          end
        end
        FN_POP: begin
          if (n_used == 0) begin
            r.status = STAT_RANGE;
          end else begin
            n_used--;
            r.value = slots[n_used];
          end
        end
        FN_INSERT: begin
          if (pos > n_used) begin
            r.status = STAT_RANGE;
          end else if (n_used >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            for (i = n_used; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = val;
            n_used++;
          end
        end
        FN_REMOVE: begin
          if (pos >= n_used) begin
            r.status = STAT_RANGE;
          end else begin
            r.value = slots[pos];
            for (i = pos; i + 1 < n_used; i++) slots[i] = slots[i+1];
            n_used--;
          end
        end
        FN_GET: begin
          if (pos >= n_used) begin
            r.status = STAT_RANGE;
          end else begin
            r.value = slots[pos];
          end
        end
        FN_FIND: begin
          r.status = STAT_MISSING;
          for (i = 0; i < n_used; i++) begin
            if (slots[i] == val) begin
              r.found_index = i[ADDR_W-1:0];
              r.status = STAT_OK;
              break;
            end
          end
        end
        FN_CLEAR: begin
          n_used = 0;
        end
        default: begin
        end
      endcase
      r.count = n_used[CNT_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_response(logic [M_TDATA_W-1:0] d, logic [1:0] u);
      res_t e;
      logic [DATA_WIDTH-1:0] v;
      logic [ADDR_W-1:0] idx;
      logic [CNT_W-1:0] c;
      v = d[0 +: DATA_WIDTH];
      idx = d[DATA_WIDTH +: ADDR_W];
      c = d[DATA_WIDTH+ADDR_W +: CNT_W];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h index %0d count %0d status %0d",
                   v, idx, c, u);
        return;
      end
      e = expected_q.pop_front();
      if (v !== e.value || idx !== e.found_index || c !== e.count || u !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %h index %0d count %0d status %0d, %s",
                   e.value, e.found_index, e.count, e.status,
                   $sformatf("got value %h index %0d count %0d status %0d", v, idx, c, u));
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic [S_TDATA_W-1:0]  s_data = '0;
  logic [FUNC_W-1:0]     s_user = '0;
  logic                  m_ready = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  list_tracker sb;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned rx_cycle;
  rx_mode_e    rx_mode;
  phase_e      phase;
  int unsigned phase_left;
  int unsigned roll;
  int unsigned grow_pct;
  int unsigned n;
  logic [FUNC_W-1:0]     fn;
  logic [ADDR_W-1:0]     pos;
  logic [DATA_WIDTH-1:0] val;

  indexed_list_store u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sends one request and, at the end of a burst, drops valid for a random gap.
  task automatic issue(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] p,
                       logic [DATA_WIDTH-1:0] v);
    s_valid <= 1'b1;
    s_data  <= S_TDATA_W'({v, p});
    s_user  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_request(f, p, v);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 12);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_ready) sb.check_response(m_axis_tdata, m_axis_tuser);
      if (rx_cycle % 128 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   m_ready <= 1'b1;
        RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
        RX_EVERY4: m_ready <= (rx_cycle % 4 == 3);
        default:   m_ready <= ($urandom_range(0, 9) == 0);
      endcase
      rx_cycle++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    sb = new();
    burst_left = 0;
    idle_cycles = 0;
    rx_cycle = 0;
    rx_mode = RX_OPEN;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(FN_POP, 0, 0);
    issue(FN_GET, 0, 0);
    issue(FN_REMOVE, 0, 0);
    issue(FN_FIND, 0, 0);
    issue(FN_INSERT, 1, 5);
    issue(FN_INSERT, 0, '1);
    issue(FN_PUSH, 8'hFF, 0);
    issue(FN_PUSH, 0, 32'h8000_0000);
    issue(FN_INSERT, 3, 32'h1234_5678);
    issue(FN_INSERT, 1, 32'hA5A5_A5A5);
    issue(FN_PUSH, 0, 0);
    issue(FN_GET, 0, 0);
    issue(FN_GET, 5, 0);
    issue(FN_GET, 6, 0);
    issue(FN_GET, 8'hFF, 0);
    issue(FN_FIND, 0, 0);
    issue(FN_FIND, 0, '1);
    issue(FN_FIND, 0, 32'hDEAD_BEEF);
    issue(FN_INSERT, 8'hFF, 1);
    issue(FN_REMOVE, 0, 0);
    issue(FN_REMOVE, 2, 0);
    issue(FN_REMOVE, 8'hC8, 0);
    issue(FN_UNUSED, 8'h5A, 32'h5A5A_5A5A);
    issue(FN_POP, 0, 0);
    issue(FN_CLEAR, 0, 0);
    issue(FN_POP, 0, 0);

    // The first phase fills the list so that full behavior is always reached.
    phase = PH_FILL;
    phase_left = 320;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (phase_left == 0) begin
        phase = phase_e'($urandom_range(0, 3));
        phase_left = (phase == PH_FILL) ? 320 : $urandom_range(30, 150);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      grow_pct = (phase == PH_GROW) ? 75 : (phase == PH_SHRINK) ? 25 : 50;
      if (phase == PH_FILL && sb.n_used < DEPTH) fn = FN_PUSH;
      else if (roll < 3) fn = (phase == PH_MIX) ? FN_CLEAR : FN_UNUSED;
      else if (roll < 12) fn = FN_GET;
      else if (roll < 22) fn = FN_FIND;
      else if ($urandom_range(0, 99) < grow_pct) fn = $urandom_range(0, 1) ? FN_PUSH : FN_INSERT;
      else fn = $urandom_range(0, 1) ? FN_POP : FN_REMOVE;

      pos = ADDR_W'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 85) begin
        if (fn == FN_INSERT)
          pos = ADDR_W'($urandom_range(0, (sb.n_used < DEPTH - 1) ? sb.n_used : DEPTH - 1));
        else if (sb.n_used > 0)
          pos = ADDR_W'($urandom_range(0, sb.n_used - 1));
      end

      // Small values and copies of stored entries make duplicates for find.
      case ($urandom_range(0, 3))
        0: val = DATA_WIDTH'($urandom());
        1: val = DATA_WIDTH'($urandom_range(0, 3));
        2: val = DATA_WIDTH'($urandom()) | {1'b1, {(DATA_WIDTH-1){1'b0}}};
        default: val = (sb.n_used > 0) ? sb.slots[$urandom_range(0, sb.n_used - 1)]
                                       : DATA_WIDTH'($urandom());
      endcase
      issue(fn, pos, val);
    end

    s_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ils_pkg.sv
hw/rtl/ils_ram.sv
hw/rtl/ils_ctrl.sv
hw/rtl/indexed_list_store.sv
bench/tb.sv
